FILE: rtl/core/plcm_pkg.sv
// Shared types and constants for the piecewise linear color map.
`timescale 1ns / 1ps

package plcm_pkg;

    localparam int NUM_POINT_REGS = 7;
    localparam int PT_IDX_W       = 3;
    localparam int COMP_W         = 16;
    localparam int WEIGHT_BITS    = 16;
    localparam int DIV_STAGES     = WEIGHT_BITS;
    localparam int APB_ADDR_W     = 6;
    localparam int APB_DATA_W     = 64;

    localparam logic [WEIGHT_BITS:0] WEIGHT_ONE      = (WEIGHT_BITS + 1)'(1) << WEIGHT_BITS;
    localparam logic [63:0]          POINT_ONE_RESET = 64'h8000_8000_8000_8000;
    localparam logic [2:0]           SEG_COUNT_RESET = 3'd1;

    typedef enum logic [2:0] {
        REG_SEGMENT_COUNT,
        REG_POINT_ZERO,
        REG_POINT_ONE,
        REG_POINT_TWO,
        REG_POINT_THREE,
        REG_POINT_FOUR,
        REG_POINT_FIVE,
        REG_POINT_SIX
    } t_reg_idx;

    // red in the lowest bits
    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
    } t_rgb;

    // bits 15:0 position, 31:16 red, 47:32 green, 63:48 blue
    typedef struct packed {
        t_rgb              color;
        logic [COMP_W-1:0] pos;
    } t_point;

    // segment set up for the divider
    typedef struct packed {
        logic [COMP_W-1:0] num;
        logic [COMP_W-1:0] den;
        logic              zero;
        logic              sat;
        t_rgb              sc;
        t_rgb              ec;
    } t_seg;

    // one divider stage
    typedef struct packed {
        logic [COMP_W-1:0]      rem;
        logic [WEIGHT_BITS-1:0] quo;
        logic [COMP_W-1:0]      den;
        logic                   zero;
        logic                   sat;
        t_rgb                   sc;
        t_rgb                   ec;
    } t_div;

endpackage

FILE: rtl/core/plcm_locate.sv
// Segment search and span setup: three pipeline stages.
`timescale 1ns / 1ps

module plcm_locate import plcm_pkg::*; #(
    parameter int MAX_POINTS = 7,
    parameter int FRAC_BITS  = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [COMP_W-1:0] i_scalar,
    input  logic [2:0]        i_seg_count,
    input  t_point            i_points [NUM_POINT_REGS],
    output logic              o_valid,
    output t_seg              o_seg
);

    localparam logic [COMP_W:0]   UNIT_POS = (COMP_W + 1)'(1) << FRAC_BITS;
    localparam logic [PT_IDX_W-1:0] LAST_SEG = PT_IDX_W'(MAX_POINTS - 1);

    // stage 0: compare against every used point
    logic [PT_IDX_W-1:0]   n_cnt;
    logic [MAX_POINTS-1:0] n_lt;
    logic                  r0_valid;
    logic [COMP_W-1:0]     r0_v;
    logic [MAX_POINTS-1:0] r0_lt;
    logic [PT_IDX_W-1:0]   r0_cnt;

    always_comb begin
        if (i_seg_count == 3'd0) begin
            n_cnt = PT_IDX_W'(1);
        end else if (i_seg_count > LAST_SEG) begin
            n_cnt = LAST_SEG;
        end else begin
            n_cnt = i_seg_count;
        end
        for (int i = 0; i < MAX_POINTS; i++) begin
            n_lt[i] = (i_scalar < i_points[i].pos) && (PT_IDX_W'(i) <= n_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_v   <= i_scalar;
            r0_lt  <= n_lt;
            r0_cnt <= n_cnt;
        end
    end

    // stage 1: first point above the scalar, pick segment ends
    logic [PT_IDX_W-1:0] w_idx;
    logic [PT_IDX_W-1:0] w_s_idx;
    logic [PT_IDX_W-1:0] w_e_idx;
    logic [PT_IDX_W-1:0] w_past;
    logic [COMP_W-1:0]   n_start;
    logic [COMP_W:0]     n_end;
    logic                r1_valid;
    logic [COMP_W-1:0]   r1_v;
    logic [COMP_W-1:0]   r1_start;
    logic [COMP_W:0]     r1_end;
    t_rgb                r1_sc;
    t_rgb                r1_ec;

    always_comb begin
        w_past = r0_cnt + PT_IDX_W'(1);
        w_idx  = w_past;
        for (int i = MAX_POINTS - 1; i >= 0; i--) begin
            if (r0_lt[i]) begin
                w_idx = PT_IDX_W'(i);
            end
        end
        // below the first point the segment starts at zero
        if (w_idx == '0) begin
            w_s_idx = '0;
            n_start = '0;
        end else begin
            w_s_idx = w_idx - PT_IDX_W'(1);
            n_start = i_points[w_s_idx].pos;
        end
        // past the last point the segment ends at one
        if (w_idx == w_past) begin
            w_e_idx = r0_cnt;
            n_end   = UNIT_POS;
        end else begin
            w_e_idx = w_idx;
            n_end   = {1'b0, i_points[w_idx].pos};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v     <= r0_v;
            r1_start <= n_start;
            r1_end   <= n_end;
            r1_sc    <= i_points[w_s_idx].color;
            r1_ec    <= i_points[w_e_idx].color;
        end
    end

    // stage 2: span, offset, degenerate and saturation flags
    logic [COMP_W:0]   w_span;
    logic [COMP_W-1:0] w_num;
    t_seg              n_seg;

    always_comb begin
        w_span     = r1_end - {1'b0, r1_start};
        w_num      = r1_v - r1_start;
        n_seg.num  = w_num;
        n_seg.den  = w_span[COMP_W-1:0];
        n_seg.zero = (r1_end <= {1'b0, r1_start});
        n_seg.sat  = !n_seg.zero && ({1'b0, w_num} >= w_span);
        n_seg.sc   = r1_sc;
        n_seg.ec   = r1_ec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_seg <= n_seg;
        end
    end

endmodule

FILE: rtl/core/plcm_divider.sv
// Pipelined restoring divider: one quotient bit of the weight per stage.
`timescale 1ns / 1ps

module plcm_divider import plcm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_seg i_seg,
    output logic o_valid,
    output t_div o_div
);

    t_div w_in    [DIV_STAGES];
    t_div n_stage [DIV_STAGES];
    t_div r_stage [DIV_STAGES];
    logic r_valid [DIV_STAGES];

    assign w_in[0] = '{
        rem:  i_seg.num,
        quo:  '0,
        den:  i_seg.den,
        zero: i_seg.zero,
        sat:  i_seg.sat,
        sc:   i_seg.sc,
        ec:   i_seg.ec
    };

    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_link
        assign w_in[k] = r_stage[k-1];
    end

    // remainder stays below the divisor, so the doubled value fits in 17 bits
    always_comb begin
        logic [COMP_W:0] shifted;
        logic [COMP_W:0] diff;
        logic            ge;
        for (int k = 0; k < DIV_STAGES; k++) begin
            shifted        = {w_in[k].rem, 1'b0};
            diff           = shifted - {1'b0, w_in[k].den};
            ge             = (shifted >= {1'b0, w_in[k].den});
            n_stage[k]     = w_in[k];
            n_stage[k].rem = ge ? diff[COMP_W-1:0] : shifted[COMP_W-1:0];
            n_stage[k].quo = {w_in[k].quo[WEIGHT_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_stage[k] <= n_stage[k];
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_div   = r_stage[DIV_STAGES-1];

endmodule

FILE: rtl/core/plcm_blend.sv
// Color blend: weight select, multiply by color difference, add start color.
`timescale 1ns / 1ps

module plcm_blend import plcm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_div,
    output logic o_valid,
    output t_rgb o_rgb
);

    localparam int NUM_CH = 3;
    localparam int PROD_W = WEIGHT_BITS + COMP_W + 3;

    // stage 0: final weight and signed color differences
    logic [WEIGHT_BITS:0]        n_frac;
    logic signed [COMP_W:0]      n_diff [NUM_CH];
    logic                        r0_valid;
    logic [WEIGHT_BITS:0]        r0_frac;
    logic signed [COMP_W:0]      r0_diff [NUM_CH];
    t_rgb                        r0_sc;

    always_comb begin
        priority if (i_div.zero) begin
            n_frac = '0;
        end else if (i_div.sat) begin
            n_frac = WEIGHT_ONE;
        end else begin
            n_frac = {1'b0, i_div.quo};
        end
        for (int c = 0; c < NUM_CH; c++) begin
            n_diff[c] = $signed({1'b0, i_div.ec[COMP_W*c +: COMP_W]})
                      - $signed({1'b0, i_div.sc[COMP_W*c +: COMP_W]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_frac <= n_frac;
            r0_sc   <= i_div.sc;
            for (int c = 0; c < NUM_CH; c++) begin
                r0_diff[c] <= n_diff[c];
            end
        end
    end

    // stage 1: weight times difference
    logic                     r1_valid;
    logic signed [PROD_W-1:0] r1_prod [NUM_CH];
    t_rgb                     r1_sc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sc <= r0_sc;
            for (int c = 0; c < NUM_CH; c++) begin
                r1_prod[c] <= $signed({1'b0, r0_frac}) * r0_diff[c];
            end
        end
    end

    // stage 2: start + floor(prod / 2^16); never leaves 16 bits
    logic signed [PROD_W-WEIGHT_BITS-1:0] w_sum [NUM_CH];
    t_rgb                                 n_rgb;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_sum[c] = $signed({3'b000, r1_sc[COMP_W*c +: COMP_W]})
                     + $signed(r1_prod[c][PROD_W-1:WEIGHT_BITS]);
            n_rgb[COMP_W*c +: COMP_W] = w_sum[c][COMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rgb <= n_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            o_valid  <= r1_valid;
        end
    end

endmodule

FILE: rtl/core/plcm_skid.sv
// Output register with a skid entry; its fill state stalls the pipeline.
`timescale 1ns / 1ps

module plcm_skid import plcm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_rgb i_data,
    output logic o_en,
    input  logic i_ready,
    output logic o_valid,
    output t_rgb o_data
);

    logic r_out_valid;
    t_rgb r_out_data;
    logic r_skid_valid;
    t_rgb r_skid_data;
    logic w_take_in;

    // the pipeline advances only while the skid entry is free
    assign o_en      = !r_skid_valid;
    assign w_take_in = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_take_in;
                if (w_take_in) begin
                    r_out_data <= i_data;
                end
            end
        end else if (w_take_in) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

FILE: rtl/core/piecewise_linear_color_map_unit.sv
// Top level of the piecewise linear color map: registers and pipeline.
`timescale 1ns / 1ps

// Maps each Q1.15 scalar to an RGB color by linear interpolation between up to seven
// programmed control points. One scalar is accepted per cycle while tready is high;
// each result passes through 3 search/setup stages, a 16-stage divider that forms the
// interpolation weight one bit per stage, 3 blend stages and the output register. A
// two-entry output buffer lets the input side keep taking items while a result waits;
// tready drops only when both entries are full. Registers sit at byte address 8*i
// (segment count at 0, points zero..six at 8..56); program them only while no items
// are in flight.
module piecewise_linear_color_map_unit import plcm_pkg::*; #(
    parameter int MAX_POINTS = 7,
    parameter int FRAC_BITS  = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [15:0]           i_s_axis_tdata,  // [15:0] scalar
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [47:0]           o_m_axis_tdata   // [15:0] red, [31:16] green, [47:32] blue
);

    // configuration registers
    logic [2:0]          r_seg_count;
    t_point              r_points [NUM_POINT_REGS];
    logic [2:0]          w_addr_idx;
    t_reg_idx            w_reg;
    logic [PT_IDX_W-1:0] w_pt;
    logic                w_wr;

    assign pready     = 1'b1;
    assign w_addr_idx = paddr[5:3];
    assign w_reg      = t_reg_idx'(w_addr_idx);
    assign w_pt       = w_addr_idx - 3'd1;
    assign w_wr       = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= SEG_COUNT_RESET;
            for (int i = 0; i < NUM_POINT_REGS; i++) begin
                r_points[i] <= '0;
            end
            r_points[1] <= POINT_ONE_RESET;
        end else if (w_wr) begin
            if (w_reg == REG_SEGMENT_COUNT) begin
                r_seg_count <= pwdata[2:0];
            end else begin
                r_points[w_pt] <= pwdata;
            end
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_SEGMENT_COUNT: prdata = {61'd0, r_seg_count};
            default:           prdata = r_points[w_pt];
        endcase
    end

    // pipeline
    logic w_en;
    logic w_in_valid;
    logic w_seg_valid;
    t_seg w_seg;
    logic w_div_valid;
    t_div w_div;
    logic w_mix_valid;
    t_rgb w_mix;
    t_rgb w_out;

    assign o_s_axis_tready = w_en;
    assign w_in_valid      = i_s_axis_tvalid && w_en;

    plcm_locate #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_locate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_in_valid),
        .i_scalar    (i_s_axis_tdata),
        .i_seg_count (r_seg_count),
        .i_points    (r_points),
        .o_valid     (w_seg_valid),
        .o_seg       (w_seg)
    );

    plcm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_seg_valid),
        .i_seg   (w_seg),
        .o_valid (w_div_valid),
        .o_div   (w_div)
    );

    plcm_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_valid),
        .i_div   (w_div),
        .o_valid (w_mix_valid),
        .o_rgb   (w_mix)
    );

    plcm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mix_valid),
        .i_data  (w_mix),
        .o_en    (w_en),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_out)
    );

    assign o_m_axis_tdata = w_out;

endmodule

FILE: rtl/core/plcm_checker.sv
// Port-level assertions for the color map top level, bound to it below.
`timescale 1ns / 1ps

module plcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    // reset empties both output entries
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("output buffer not empty after reset");

    // a blocked result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // input back-pressure only with a result waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no result pending");

    // an output transfer frees the skid entry
    a_transfer_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready |=> o_s_axis_tready)
        else $error("input still stalled after output transfer");

    // a full buffer stays full while the output is blocked
    a_full_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready && !i_m_axis_tready |=> !o_s_axis_tready)
        else $error("buffer entry dropped while output blocked");

endmodule

bind piecewise_linear_color_map_unit plcm_checker u_plcm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: tb/piecewise_linear_color_map_unit_tb.sv
// Self-checking testbench for the piecewise linear color map unit.
`timescale 1ns / 1ps

module piecewise_linear_color_map_unit_tb;
    import plcm_pkg::*;

    localparam int MAX_POINTS = 7;
    localparam int FRAC_BITS  = 15;
    localparam longint UNIT_POS   = 64'sd1 << FRAC_BITS;
    localparam longint WEIGHT_MAX = 64'sd1 << WEIGHT_BITS;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 38;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_ITEM,
        ROW_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_reg_idx    r;
        logic [63:0] val;
        logic [15:0] scalar;
        t_rgb        want;
    } t_row;

    // ROW_KNOWN rows carry a hand-computed color; ROW_ITEM rows go through the predictor
    localparam t_row DIRECTED [32] = '{
        // reset table: black at 0 rising to 1.0 gray at 1.0
        '{ROW_KNOWN, REG_SEGMENT_COUNT, 64'h0, 16'h0000, 48'h0000_0000_0000},
        '{ROW_KNOWN, REG_SEGMENT_COUNT, 64'h0, 16'h0001, 48'h0001_0001_0001},
        '{ROW_KNOWN, REG_SEGMENT_COUNT, 64'h0, 16'h4000, 48'h4000_4000_4000},
        '{ROW_KNOWN, REG_SEGMENT_COUNT, 64'h0, 16'h7FFF, 48'h7FFF_7FFF_7FFF},
        '{ROW_KNOWN, REG_SEGMENT_COUNT, 64'h0, 16'h8000, 48'h8000_8000_8000},
        '{ROW_KNOWN, REG_SEGMENT_COUNT, 64'h0, 16'hFFFF, 48'h8000_8000_8000},
        // segment count of zero behaves as one
        '{ROW_WRITE, REG_SEGMENT_COUNT, 64'h0, 16'h0000, 48'h0},
        '{ROW_KNOWN, REG_SEGMENT_COUNT, 64'h0, 16'h4000, 48'h4000_4000_4000},
        '{ROW_WRITE, REG_POINT_ZERO,  64'h0100_0200_0300_1000, 16'h0000, 48'h0},
        '{ROW_WRITE, REG_POINT_ONE,   64'h2000_4000_6000_2000, 16'h0000, 48'h0},
        '{ROW_WRITE, REG_POINT_TWO,   64'h8000_0000_8000_3000, 16'h0000, 48'h0},
        '{ROW_WRITE, REG_POINT_THREE, 64'h0000_8000_0000_4000, 16'h0000, 48'h0},
        '{ROW_WRITE, REG_POINT_FOUR,  64'h7FFF_1111_2222_5000, 16'h0000, 48'h0},
        '{ROW_WRITE, REG_POINT_FIVE,  64'h0001_8000_4000_6000, 16'h0000, 48'h0},
        '{ROW_WRITE, REG_POINT_SIX,   64'h1234_0000_8000_7000, 16'h0000, 48'h0},
        // count of seven clamps to six segments
        '{ROW_WRITE, REG_SEGMENT_COUNT, 64'h7, 16'h0000, 48'h0},
        // below the first point: first point's color
        '{ROW_KNOWN, REG_SEGMENT_COUNT, 64'h0, 16'h0000, 48'h0100_0200_0300},
        '{ROW_ITEM,  REG_SEGMENT_COUNT, 64'h0, 16'h0800, 48'h0},
        '{ROW_ITEM,  REG_SEGMENT_COUNT, 64'h0, 16'h1000, 48'h0},
        '{ROW_ITEM,  REG_SEGMENT_COUNT, 64'h0, 16'h1800, 48'h0},
        '{ROW_ITEM,  REG_SEGMENT_COUNT, 64'h0, 16'h3FFF, 48'h0},
        '{ROW_ITEM,  REG_SEGMENT_COUNT, 64'h0, 16'h5555, 48'h0},
        '{ROW_ITEM,  REG_SEGMENT_COUNT, 64'h0, 16'h6FFF, 48'h0},
        '{ROW_ITEM,  REG_SEGMENT_COUNT, 64'h0, 16'h7000, 48'h0},
        '{ROW_ITEM,  REG_SEGMENT_COUNT, 64'h0, 16'h7800, 48'h0},
        // well past 1.0: weight saturates, last color
        '{ROW_KNOWN, REG_SEGMENT_COUNT, 64'h0, 16'hFFFF, 48'h1234_0000_8000},
        // last point beyond 1.0 gives a negative span
        '{ROW_WRITE, REG_POINT_TWO, 64'h0AAA_0BBB_0CCC_C000, 16'h0000, 48'h0},
        '{ROW_WRITE, REG_SEGMENT_COUNT, 64'h2, 16'h0000, 48'h0},
        '{ROW_ITEM,  REG_SEGMENT_COUNT, 64'h0, 16'h1800, 48'h0},
        '{ROW_ITEM,  REG_SEGMENT_COUNT, 64'h0, 16'h9000, 48'h0},
        '{ROW_KNOWN, REG_SEGMENT_COUNT, 64'h0, 16'hD000, 48'h0AAA_0BBB_0CCC},
        '{ROW_KNOWN, REG_SEGMENT_COUNT, 64'h0, 16'hFFFF, 48'h0AAA_0BBB_0CCC}
    };

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [15:0]           s_data  = '0;  // [15:0] scalar
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [47:0]           m_data;        // [15:0] red, [31:16] green, [47:32] blue

    // register shadow used by the predictor
    logic [2:0] seg_shadow = SEG_COUNT_RESET;
    t_point     pt_shadow [NUM_POINT_REGS] = '{64'h0, POINT_ONE_RESET, 64'h0, 64'h0,
                                               64'h0, 64'h0, 64'h0};

    t_rgb pending_rgb [$];
    int   mismatches = 0;
    int   cycles     = 0;
    bit   idle_on    = 1'b1;
    bit   hold_req   = 1'b0;

    piecewise_linear_color_map_unit #(
        .MAX_POINTS(MAX_POINTS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] blend16(input longint frac, input logic [15:0] sc,
                                            input logic [15:0] ec);
        longint mix;
        mix = frac * longint'(ec) + (WEIGHT_MAX - frac) * longint'(sc);
        return 16'(mix >>> WEIGHT_BITS);
    endfunction

    function automatic t_rgb map_scalar(input logic [15:0] v);
        int     n;
        int     idx;
        int     s_idx;
        int     e_idx;
        longint start_pos;
        longint end_pos;
        longint span;
        longint frac;
        t_rgb   sc;
        t_rgb   ec;
        t_rgb   res;
        n = int'(seg_shadow);
        if (n < 1) n = 1;
        if (n > MAX_POINTS - 1) n = MAX_POINTS - 1;
        // first used point strictly above the scalar
        idx = 0;
        while (idx <= n && v >= pt_shadow[idx].pos) idx++;
        s_idx     = (idx == 0) ? 0 : idx - 1;
        start_pos = (idx == 0) ? 0 : longint'(pt_shadow[s_idx].pos);
        e_idx     = (idx == n + 1) ? n : idx;
        end_pos   = (idx == n + 1) ? UNIT_POS : longint'(pt_shadow[e_idx].pos);
        span = end_pos - start_pos;
        frac = 0;
        if (span > 0) begin
            frac = ((longint'(v) - start_pos) * WEIGHT_MAX) / span;
            if (frac < 0) frac = 0;
            if (frac > WEIGHT_MAX) frac = WEIGHT_MAX;
        end
        sc = pt_shadow[s_idx].color;
        ec = pt_shadow[e_idx].color;
        res.red   = blend16(frac, sc.red, ec.red);
        res.green = blend16(frac, sc.green, ec.green);
        res.blue  = blend16(frac, sc.blue, ec.blue);
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
        mismatches++;
        $display("MISMATCH @%0t %s: got %h want %h", $time, what, got, want);
    endtask

    // setup then access phase; psel is dropped afterwards to keep back-to-back writes apart
    task automatic write_reg(input t_reg_idx r, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (r == REG_SEGMENT_COUNT) seg_shadow = val[2:0];
        else pt_shadow[int'(r) - 1] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_scalar(input logic [15:0] v, input bit known, input t_rgb want);
        while (idle_on && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        do @(posedge i_clk); while (!s_ready);
        pending_rgb.push_back(known ? want : map_scalar(v));
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (i_rst_n && m_valid && m_ready) begin
            got = t_rgb'(m_data);
            if (pending_rgb.size() == 0) begin
                flag_mismatch("result with no input pending", got, '0);
            end else begin
                want = pending_rgb.pop_front();
                for (int c = 0; c < 3; c++) begin
                    if (got[16*c +: 16] !== want[16*c +: 16])
                        flag_mismatch(c == 0 ? "red" : (c == 1 ? "green" : "blue"),
                                      got, want);
                end
            end
        end
    end

    // output side: random stalls plus one long hold-off on request
    initial begin : sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(99) < 22) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_row        row;
        logic [63:0] cfg [8];
        logic [15:0] pos_list [$];
        logic [15:0] v;
        int          pick;
        int          k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            if (row.kind == ROW_WRITE) begin
                drain_pipeline();
                write_reg(row.r, row.val);
            end else begin
                send_scalar(row.scalar, row.kind == ROW_KNOWN, row.want);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // no stalls on either side for a couple of phases
            idle_on = !(phase == 7 || phase == 8);
            case (phase)
                0: begin
                    cfg[0] = 64'h0;
                    for (int r = 1; r < 8; r++) cfg[r] = 64'h0;
                end
                1: begin
                    cfg[0] = 64'h7;
                    for (int r = 1; r < 8; r++) cfg[r] = 64'h8000_8000_8000_8000;
                end
                2: begin
                    cfg[0] = 64'hFFFF_FFFF_FFFF_FFFF;
                    for (int r = 1; r < 8; r++) cfg[r] = 64'hFFFF_FFFF_FFFF_FFFF;
                end
                3, 6, 9: begin
                    // unsorted noise over every bit
                    for (int r = 0; r < 8; r++) cfg[r] = {$urandom, $urandom};
                end
                default: begin
                    pos_list = {};
                    for (int r = 0; r < NUM_POINT_REGS; r++)
                        pos_list.push_back(16'($urandom_range(32768)));
                    pos_list.sort();
                    cfg[0] = 64'($urandom_range(6, 1));
                    for (int r = 0; r < NUM_POINT_REGS; r++)
                        cfg[r + 1] = {16'($urandom_range(32768)), 16'($urandom_range(32768)),
                                      16'($urandom_range(32768)), pos_list[r]};
                end
            endcase
            drain_pipeline();
            for (int r = 0; r < 8; r++) write_reg(t_reg_idx'(r), cfg[r]);

            for (int n_item = 0; n_item < PHASE_ITEMS; n_item++) begin
                if (phase == 5 && n_item == 3) hold_req = 1'b1;
                pick = $urandom_range(99);
                if (pick < 60) begin
                    v = 16'($urandom_range(32768));
                end else if (pick < 75) begin
                    // on or next to a control point
                    k = $urandom_range(NUM_POINT_REGS - 1);
                    v = pt_shadow[k].pos + 16'($urandom_range(2)) - 16'd1;
                end else if (pick < 85) begin
                    v = 16'($urandom_range(65535, 32768));
                end else begin
                    v = 16'($urandom);
                end
                send_scalar(v, 1'b0, '0);
            end
        end

        idle_on = 1'b1;
        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_rgb.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
